>>> hw/rtl/clm_pkg.sv
package clm_pkg;

  // Default width of the message length and body counter
  localparam int unsigned LENGTH_BITS_DEF = 31;

  // Width of the decimal value accumulator (holds up to 2^31)
  localparam int unsigned ACC_W = 32;

  // Result kinds
  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // Input actions
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Line phases: 1..14 track the key match position
  localparam logic [4:0] PH_LEAD      = 5'd0;
  localparam logic [4:0] PH_VAL_LEAD  = 5'd15;
  localparam logic [4:0] PH_VAL_SIGN  = 5'd16;
  localparam logic [4:0] PH_VAL_DIG   = 5'd17;
  localparam logic [4:0] PH_VAL_TRAIL = 5'd18;
  localparam logic [4:0] PH_VAL_BAD   = 5'd19;
  localparam logic [4:0] PH_OTHER     = 5'd20;
  localparam logic [4:0] KEY_LEN      = 5'd15;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Terminator progress codes
  localparam logic [1:0] TP_NONE = 2'd0;
  localparam logic [1:0] TP_CR   = 2'd1;
  localparam logic [1:0] TP_CRLF = 2'd2;
  localparam logic [1:0] TP_CRLFCR = 2'd3;

  // One result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       last;
  } clm_result_t;

  // Header key text "Content-Length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h4c; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3a; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // HT, LF, VT, FF, CR and space
  function automatic logic is_space(input logic [7:0] c);
    return (c inside {[8'h09:8'h0d], 8'h20});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[CH_ZERO:CH_NINE]});
  endfunction

endpackage

>>> hw/rtl/clm_in_if.sv
interface clm_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

>>> hw/rtl/clm_out_if.sv
interface clm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] body_byte;
  logic       last;

  modport source (output valid, output kind, output body_byte, output last, input ready);
  modport sink   (input valid, input kind, input body_byte, input last, output ready);
endinterface

>>> hw/rtl/content_length_message_deframer.sv
// Content-Length message deframer.
// in_ch carries one word per byte of the link stream (action 0) or a clear
// command (action 1). The header is scanned up to CR LF CR LF; the last
// "Content-Length:" line sets the body length. out_ch carries body bytes
// (kind 0, last set on the final one), an empty-message word (kind 1) or a
// malformed-header word (kind 2).
// Throughput: one input word per clock while in_ch.ready is high. Each word is
// parsed in the cycle it is accepted; its result is registered in the output or skid register.
// The per-byte path is one key compare plus one multiply-by-ten add and
// range compare on the 32-bit length accumulator.
// A two-entry output (result register plus skid register) lets the block
// take the next word while a result waits; in_ch.ready drops only when both
// are full, and rises again as soon as the receiver takes a word.
// Reset (rst_n low, synchronous) and the clear command both return the
// parser to header scan with no valid length; reset also empties the output.
module content_length_message_deframer #(
  parameter int unsigned LENGTH_BITS = clm_pkg::LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  clm_in_if.sink    in_ch,
  clm_out_if.source out_ch
);

  // Parse state
  logic                          in_body_r, in_body_nxt;
  logic [1:0]                    term_r, term_nxt;
  logic [4:0]                    phase_r, phase_nxt;
  logic [clm_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic                          known_r, known_nxt;
  logic [LENGTH_BITS-1:0]        msg_len_r, msg_len_nxt;
  logic [LENGTH_BITS-1:0]        remain_r, remain_nxt;

  // Output staging
  logic                  out_valid_r, skid_valid_r;
  clm_pkg::clm_result_t  out_r, skid_r;
  clm_pkg::clm_result_t  res;
  logic                  res_valid;

  logic                        accept;
  logic                        taken;
  logic [7:0]                  c;
  logic                        done;
  logic [clm_pkg::ACC_W+3:0]   acc_x10;
  logic [clm_pkg::ACC_W+3:0]   acc_lim;

  assign accept = in_ch.valid && in_ch.ready;
  assign taken  = out_valid_r && out_ch.ready;
  assign c      = in_ch.data_byte;

  assign in_ch.ready      = !skid_valid_r;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_r.kind;
  assign out_ch.body_byte = out_r.body_byte;
  assign out_ch.last      = out_r.last;

  // Multiply accumulator by ten and add the digit
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                 + {{(clm_pkg::ACC_W-4){1'b0}}, (c - clm_pkg::CH_ZERO)};
  assign acc_lim = neg_r ? (36'd1 << 31) : ((36'd1 << 31) - 36'd1);

  // Parse one word
  always_comb begin
    in_body_nxt = in_body_r;
    term_nxt    = term_r;
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    known_nxt   = known_r;
    msg_len_nxt = msg_len_r;
    remain_nxt  = remain_r;
    res_valid   = 1'b0;
    res         = '{kind: clm_pkg::KIND_BODY, body_byte: 8'h00, last: 1'b0};
    done        = 1'b0;
    if (accept) begin
      if (in_ch.action == clm_pkg::ACT_CLEAR) begin
        in_body_nxt = 1'b0;
        term_nxt    = clm_pkg::TP_NONE;
        phase_nxt   = clm_pkg::PH_LEAD;
        acc_nxt     = '0;
        neg_nxt     = 1'b0;
        known_nxt   = 1'b0;
        msg_len_nxt = '0;
        remain_nxt  = '0;
      end else if (in_body_r) begin
        // Pass a body byte through
        res_valid     = 1'b1;
        res.body_byte = c;
        res.last      = (remain_r <= LENGTH_BITS'(1));
        if (remain_r <= LENGTH_BITS'(1)) begin
          remain_nxt  = '0;
          in_body_nxt = 1'b0;
          term_nxt    = clm_pkg::TP_NONE;
          phase_nxt   = clm_pkg::PH_LEAD;
          acc_nxt     = '0;
          neg_nxt     = 1'b0;
          known_nxt   = 1'b0;
        end else begin
          remain_nxt = remain_r - LENGTH_BITS'(1);
        end
      end else begin
        // Track the CR LF CR LF terminator
        if (c == clm_pkg::CH_CR) begin
          term_nxt = (term_r == clm_pkg::TP_CRLF) ? clm_pkg::TP_CRLFCR : clm_pkg::TP_CR;
        end else if (c == clm_pkg::CH_LF) begin
          done     = (term_r == clm_pkg::TP_CRLFCR);
          term_nxt = (term_r == clm_pkg::TP_CR) ? clm_pkg::TP_CRLF : clm_pkg::TP_NONE;
        end else begin
          term_nxt = clm_pkg::TP_NONE;
        end

        // Advance the header line scanner
        if (c == clm_pkg::CH_LF) begin
          if (phase_r == clm_pkg::PH_VAL_DIG || phase_r == clm_pkg::PH_VAL_TRAIL) begin
            if ((neg_r && acc_r != '0) || (acc_r[clm_pkg::ACC_W-1:LENGTH_BITS] != '0)) begin
              known_nxt = 1'b0;
            end else begin
              known_nxt   = 1'b1;
              msg_len_nxt = acc_r[LENGTH_BITS-1:0];
            end
          end else if (phase_r >= clm_pkg::PH_VAL_LEAD && phase_r <= clm_pkg::PH_VAL_BAD) begin
            known_nxt = 1'b0;
          end
          phase_nxt = clm_pkg::PH_LEAD;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
        end else if (phase_r == clm_pkg::PH_LEAD) begin
          if (!clm_pkg::is_space(c)) begin
            phase_nxt = (c == clm_pkg::key_char(4'd0)) ? 5'd1 : clm_pkg::PH_OTHER;
          end
        end else if (phase_r < clm_pkg::KEY_LEN) begin
          if (c == clm_pkg::key_char(phase_r[3:0])) begin
            phase_nxt = (phase_r + 5'd1 == clm_pkg::KEY_LEN) ? clm_pkg::PH_VAL_LEAD
                                                             : phase_r + 5'd1;
          end else begin
            phase_nxt = clm_pkg::PH_OTHER;
          end
        end else if (phase_r == clm_pkg::PH_VAL_LEAD || phase_r == clm_pkg::PH_VAL_SIGN ||
                     phase_r == clm_pkg::PH_VAL_DIG) begin
          if (clm_pkg::is_digit(c)) begin
            if (acc_x10 > acc_lim) begin
              phase_nxt = clm_pkg::PH_VAL_BAD;
            end else begin
              acc_nxt   = acc_x10[clm_pkg::ACC_W-1:0];
              phase_nxt = clm_pkg::PH_VAL_DIG;
            end
          end else if (phase_r == clm_pkg::PH_VAL_LEAD && clm_pkg::is_space(c)) begin
            phase_nxt = phase_r;
          end else if (phase_r == clm_pkg::PH_VAL_LEAD &&
                       (c == clm_pkg::CH_PLUS || c == clm_pkg::CH_MINUS)) begin
            neg_nxt   = (c == clm_pkg::CH_MINUS);
            phase_nxt = clm_pkg::PH_VAL_SIGN;
          end else if (phase_r == clm_pkg::PH_VAL_DIG && clm_pkg::is_space(c)) begin
            phase_nxt = clm_pkg::PH_VAL_TRAIL;
          end else begin
            phase_nxt = clm_pkg::PH_VAL_BAD;
          end
        end else if (phase_r == clm_pkg::PH_VAL_TRAIL) begin
          if (!clm_pkg::is_space(c)) begin
            phase_nxt = clm_pkg::PH_VAL_BAD;
          end
        end else if (phase_r > clm_pkg::PH_OTHER) begin
          phase_nxt = clm_pkg::PH_OTHER;
        end

        // Close the header
        if (done) begin
          if (!known_nxt) begin
            res_valid = 1'b1;
            res.kind  = clm_pkg::KIND_DROP;
          end else if (msg_len_nxt == '0) begin
            res_valid = 1'b1;
            res.kind  = clm_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            remain_nxt  = msg_len_nxt;
            in_body_nxt = 1'b1;
          end
          term_nxt  = clm_pkg::TP_NONE;
          phase_nxt = clm_pkg::PH_LEAD;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          known_nxt = 1'b0;
        end
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      term_r    <= clm_pkg::TP_NONE;
      phase_r   <= clm_pkg::PH_LEAD;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      known_r   <= 1'b0;
      msg_len_r <= '0;
      remain_r  <= '0;
    end else begin
      in_body_r <= in_body_nxt;
      term_r    <= term_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      known_r   <= known_nxt;
      msg_len_r <= msg_len_nxt;
      remain_r  <= remain_nxt;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (taken) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || taken) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (taken) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (taken) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || taken) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

`ifndef ASSERT_OFF
  // The skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while the output register is empty");

  // A body in progress always has bytes left to send
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (remain_r != '0))
    else $error("body mode with zero bytes remaining");

  // A dropped header never carries last or data
  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == clm_pkg::KIND_DROP |-> !out_r.last && out_r.body_byte == 8'h00)
    else $error("malformed-header word carries last or data");

  // A clear returns the parser to header scan
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.action == clm_pkg::ACT_CLEAR
    |=> !in_body_r && !known_r && term_r == clm_pkg::TP_NONE && phase_r == clm_pkg::PH_LEAD)
    else $error("clear did not reset the parser");

  // A clear never produces a result
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.action == clm_pkg::ACT_CLEAR |-> !res_valid)
    else $error("clear produced a result");
`endif

endmodule
